FILE: rtl/core/wsam_pkg.sv
// Shared constants and types for the wallpaper source address mapper.
package wsam_pkg;

  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned TASKBAR_HEIGHT = 32;
  localparam int unsigned GRID_STEP      = 32;

  localparam int unsigned CW  = 12;  // coordinate width
  localparam int unsigned DW  = 13;  // dimension register width
  localparam int unsigned NW  = 24;  // dividend width
  localparam int unsigned AW  = 32;  // address width
  localparam int unsigned SPS = 2;   // divide steps per pipeline stage

  typedef enum logic [2:0] {
    KIND_IMAGE   = 3'd0,
    KIND_BORDER  = 3'd1,
    KIND_BG      = 3'd2,
    KIND_GRID    = 3'd3,
    KIND_OUTSIDE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_FILL   = 2'd0,
    MODE_CENTER = 2'd1,
    MODE_TILE   = 2'd2,
    MODE_ALT    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_IMAGE_W  = 3'd2,
    REG_IMAGE_H  = 3'd3,
    REG_MODE     = 3'd4,
    REG_PRESENT  = 3'd5,
    REG_BASE     = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

endpackage

FILE: rtl/core/wsam_div.sv
// Pipelined restoring divider, quotient and remainder, fixed latency.
module wsam_div
  import wsam_pkg::*;
(
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [CW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned ST = CW / SPS;

  typedef struct packed {
    logic [DW:0]   rem;
    logic [CW-1:0] low;
    logic [CW-1:0] quo;
    logic [DW-1:0] den;
  } dstage_t;

  dstage_t st_r   [ST];
  dstage_t st_nxt [ST];

  always_comb begin
    dstage_t     cur;
    logic [DW:0] trial;
    for (int s = 0; s < ST; s++) begin
      if (s == 0) begin
        cur.rem = (DW+1)'(num_i[NW-1:CW]);
        cur.low = num_i[CW-1:0];
        cur.quo = '0;
        cur.den = den_i;
      end else begin
        cur = st_r[s-1];
      end
      for (int k = 0; k < SPS; k++) begin
        trial   = {cur.rem[DW-1:0], cur.low[CW-1]};
        cur.low = {cur.low[CW-2:0], 1'b0};
        if (trial >= {1'b0, cur.den}) begin
          cur.rem = trial - {1'b0, cur.den};
          cur.quo = {cur.quo[CW-2:0], 1'b1};
        end else begin
          cur.rem = trial;
          cur.quo = {cur.quo[CW-2:0], 1'b0};
        end
      end
      st_nxt[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ST; s++) st_r[s] <= st_nxt[s];
  end

  assign quo_o = st_r[ST-1].quo;
  assign rem_o = st_r[ST-1].rem[DW-1:0];

endmodule

FILE: rtl/core/wallpaper_source_address_mapper_core.sv
// Top level: wallpaper pixel classifier and source address pipeline.
//
//  channel | handshake            | payload
//  in      | start / busy         | in_dest_x, in_dest_y
//  out     | out_valid strobe     | out_pixel_kind, out_source_address, out_x, out_y
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle; each result passes the capture, classify, divider, multiply and output registers.
// The divider yields a 12-bit quotient, two quotient bits per stage.
// busy and cfg_ready stay constant; the receiver takes every strobe.
// Synchronous active-low reset clears valid bits and restores the registers.
module wallpaper_source_address_mapper_core
  import wsam_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [CW-1:0] in_dest_x,
  input  logic [CW-1:0] in_dest_y,
  output logic          out_valid,
  output logic [2:0]    out_pixel_kind,
  output logic [AW-1:0] out_source_address,
  output logic [CW-1:0] out_x,
  output logic [CW-1:0] out_y,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [AW-1:0] cfg_data
);

  localparam int unsigned ST = CW / SPS;
  localparam logic [DW-1:0] MAXD = DW'(MAX_DIM);
  localparam logic [DW-1:0] TBH  = DW'(TASKBAR_HEIGHT);

  typedef struct packed {
    kind_t         kind;
    logic          center;
    logic          tile;
    logic          zx;
    logic          zy;
    logic [CW-1:0] csx;
    logic [CW-1:0] csy;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } side_t;

  logic [DW-1:0] sw_r, sh_r, iw_r, ih_r;
  mode_t         mode_r;
  logic          present_r;
  logic [AW-1:0] base_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r      <= DW'(1024);
      sh_r      <= DW'(768);
      iw_r      <= DW'(1024);
      ih_r      <= DW'(768);
      mode_r    <= MODE_FILL;
      present_r <= 1'b0;
      base_r    <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_W: sw_r      <= cfg_data[DW-1:0];
        REG_SCREEN_H: sh_r      <= cfg_data[DW-1:0];
        REG_IMAGE_W:  iw_r      <= cfg_data[DW-1:0];
        REG_IMAGE_H:  ih_r      <= cfg_data[DW-1:0];
        REG_MODE:     mode_r    <= mode_t'(cfg_data[1:0]);
        REG_PRESENT:  present_r <= cfg_data[0];
        REG_BASE:     base_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] sw, sh, iw, ih, dh;
  assign sw = (sw_r > MAXD) ? MAXD : sw_r;
  assign sh = (sh_r > MAXD) ? MAXD : sh_r;
  assign iw = (iw_r > MAXD) ? MAXD : iw_r;
  assign ih = (ih_r > MAXD) ? MAXD : ih_r;
  assign dh = (sh > TBH) ? sh - TBH : sh;

  // stage 1: capture request
  logic          v1_r;
  logic [CW-1:0] x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    x1_r <= in_dest_x;
    y1_r <= in_dest_y;
  end

  // stage 2: classify, center offsets, dividend setup
  logic signed [DW:0]   dxs, dys, oxs, oys;
  logic signed [DW+1:0] ixs, iys;
  logic                 in_img, outside, dot, is_center, is_tile;
  logic [NW:0]          px, py;
  side_t                side2;
  logic [NW-1:0]        numx2, numy2;
  logic [DW-1:0]        denx2, deny2;

  always_comb begin
    outside   = ({1'b0, x1_r} >= sw) || ({1'b0, y1_r} >= dh);
    dot       = ((x1_r % GRID_STEP) == 0) && ((y1_r % GRID_STEP) == 0);
    is_center = (mode_r == MODE_CENTER);
    is_tile   = (mode_r == MODE_TILE);
    dxs = $signed({1'b0, sw}) - $signed({1'b0, iw});
    dys = $signed({1'b0, dh}) - $signed({1'b0, ih});
    oxs = (dxs + $signed((DW+1)'(dxs[DW]))) >>> 1;
    oys = (dys + $signed((DW+1)'(dys[DW]))) >>> 1;
    ixs = $signed({3'b0, x1_r}) - (DW+2)'(oxs);
    iys = $signed({3'b0, y1_r}) - (DW+2)'(oys);
    in_img = !ixs[DW+1] && !iys[DW+1]
             && (ixs[DW:0] < {1'b0, iw}) && (iys[DW:0] < {1'b0, ih});
    if (outside)         side2.kind = KIND_OUTSIDE;
    else if (!present_r) side2.kind = dot ? KIND_GRID : KIND_BG;
    else if (is_center)  side2.kind = in_img ? KIND_IMAGE : KIND_BORDER;
    else                 side2.kind = KIND_IMAGE;
    side2.center = is_center;
    side2.tile   = is_tile;
    side2.zx     = (iw == '0);
    side2.zy     = (ih == '0);
    side2.csx    = ixs[CW-1:0];
    side2.csy    = iys[CW-1:0];
    side2.x      = x1_r;
    side2.y      = y1_r;
    px = x1_r * iw;
    py = y1_r * ih;
    numx2 = is_tile ? NW'(x1_r) : px[NW-1:0];
    numy2 = is_tile ? NW'(y1_r) : py[NW-1:0];
    denx2 = is_tile ? iw : sw;
    deny2 = is_tile ? ih : dh;
  end

  logic          v2_r;
  side_t         side2_r;
  logic [NW-1:0] numx_r, numy_r;
  logic [DW-1:0] denx_r, deny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    side2_r <= side2;
    numx_r  <= numx2;
    numy_r  <= numy2;
    denx_r  <= denx2;
    deny_r  <= deny2;
  end

  // divider stages
  logic [CW-1:0] qx, qy;
  logic [DW-1:0] rx, ry;

  wsam_div u_div_x (.clk(clk), .num_i(numx_r), .den_i(denx_r), .quo_o(qx), .rem_o(rx));
  wsam_div u_div_y (.clk(clk), .num_i(numy_r), .den_i(deny_r), .quo_o(qy), .rem_o(ry));

  logic  dv_r   [ST];
  side_t dside_r[ST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ST; s++) dv_r[s] <= 1'b0;
    end else begin
      dv_r[0] <= v2_r;
      for (int s = 1; s < ST; s++) dv_r[s] <= dv_r[s-1];
    end
    dside_r[0] <= side2_r;
    for (int s = 1; s < ST; s++) dside_r[s] <= dside_r[s-1];
  end

  // row offset multiply
  side_t         sd;
  logic [CW-1:0] sx, sy;
  logic [NW:0]   prod;

  always_comb begin
    sd = dside_r[ST-1];
    if (sd.center) begin
      sx = sd.csx;
      sy = sd.csy;
    end else if (sd.tile) begin
      sx = sd.zx ? '0 : rx[CW-1:0];
      sy = sd.zy ? '0 : ry[CW-1:0];
    end else begin
      sx = qx;
      sy = qy;
    end
    prod = sy * iw;
  end

  logic          vm_r;
  side_t         sidem_r;
  logic [NW:0]   prod_r;
  logic [CW-1:0] sx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else        vm_r <= dv_r[ST-1];
    sidem_r <= sd;
    prod_r  <= prod;
    sx_r    <= sx;
  end

  // address add and output register
  logic [AW-1:0] addr;
  assign addr = base_r + AW'(prod_r) + AW'(sx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vm_r;
    out_pixel_kind     <= sidem_r.kind;
    out_source_address <= (sidem_r.kind == KIND_IMAGE) ? addr : '0;
    out_x              <= sidem_r.x;
    out_y              <= sidem_r.y;
  end

endmodule

FILE: bench/tb_wallpaper_source_address_mapper_core.sv
// Testbench for the wallpaper source address mapper: random and directed pixel requests
`timescale 1ns / 100ps
module tb_wallpaper_source_address_mapper_core;
  import wsam_pkg::*;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } pixel_req_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [AW-1:0] addr;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } pixel_res_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [CW-1:0] in_dest_x;
  logic [CW-1:0] in_dest_y;
  logic          out_valid;
  logic [2:0]    out_pixel_kind;
  logic [AW-1:0] out_source_address;
  logic [CW-1:0] out_x;
  logic [CW-1:0] out_y;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [AW-1:0] cfg_data;

  wallpaper_source_address_mapper_core i_dut (.*);

  pixel_req_t  pending_q[$];
  pixel_res_t  expected_q[$];
  logic [12:0] m_sw, m_sh, m_iw, m_ih;
  logic [1:0]  m_mode;
  logic        m_present;
  logic [31:0] m_base;
  int          errors;
  int          checked;
  int          cycles;
  int          idle_pct;
  bit          cfg_pending;
  reg_idx_t    cfg_pend_idx;
  logic [31:0] cfg_pend_data;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clampd(logic [12:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic pixel_res_t map_pixel(pixel_req_t r);
    pixel_res_t  res;
    int unsigned sw, sh, iw, ih, dh, sx, sy;
    int          ox, oy, ix, iy;
    sw = clampd(m_sw);
    sh = clampd(m_sh);
    iw = clampd(m_iw);
    ih = clampd(m_ih);
    dh = (sh > TASKBAR_HEIGHT) ? sh - TASKBAR_HEIGHT : sh;
    sx = 0;
    sy = 0;
    res.x = r.x;
    res.y = r.y;
    res.addr = '0;
    if (r.x >= sw || r.y >= dh) begin
      res.kind = KIND_OUTSIDE;
    end else if (!m_present) begin
      res.kind = (r.x % GRID_STEP == 0 && r.y % GRID_STEP == 0) ? KIND_GRID : KIND_BG;
    end else if (m_mode == MODE_CENTER) begin
      ox = (int'(sw) - int'(iw)) / 2;
      oy = (int'(dh) - int'(ih)) / 2;
      ix = int'(r.x) - ox;
      iy = int'(r.y) - oy;
      if (ix >= 0 && iy >= 0 && ix < int'(iw) && iy < int'(ih)) begin
        res.kind = KIND_IMAGE;
        sx = ix;
        sy = iy;
      end else begin
        res.kind = KIND_BORDER;
      end
    end else if (m_mode == MODE_TILE) begin
      res.kind = KIND_IMAGE;
      sx = (iw == 0) ? 0 : r.x % iw;
      sy = (ih == 0) ? 0 : r.y % ih;
    end else begin
      res.kind = KIND_IMAGE;
      sx = r.x * iw / sw;
      sy = r.y * ih / dh;
    end
    if (res.kind == KIND_IMAGE)
      res.addr = m_base + sy * iw + sx;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (x=%0d y=%0d)", what, got, want,
             out_x, out_y);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_q.push_back(map_pixel({in_dest_x, in_dest_y}));
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        {in_dest_x, in_dest_y} <= pending_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      {in_dest_x, in_dest_y} <= pending_q.pop_front();
      start <= 1'b1;
    end
  end

  // config channel
  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      cfg_pending <= 1'b0;
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_W: m_sw <= cfg_data[12:0];
        REG_SCREEN_H: m_sh <= cfg_data[12:0];
        REG_IMAGE_W:  m_iw <= cfg_data[12:0];
        REG_IMAGE_H:  m_ih <= cfg_data[12:0];
        REG_MODE:     m_mode <= cfg_data[1:0];
        REG_PRESENT:  m_present <= cfg_data[0];
        REG_BASE:     m_base <= cfg_data;
        default: ;
      endcase
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_pend_idx;
      cfg_data <= cfg_pend_data;
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_x), 32'd0);
      end else begin
        e = expected_q.pop_front();
        checked <= checked + 1;
        if (out_pixel_kind !== e.kind)
          report_mismatch("pixel_kind", 32'(out_pixel_kind), 32'(e.kind));
        if (out_source_address !== e.addr)
          report_mismatch("source_address", out_source_address, e.addr);
        if (out_x !== e.x) report_mismatch("out_x", 32'(out_x), 32'(e.x));
        if (out_y !== e.y) report_mismatch("out_y", 32'(out_y), 32'(e.y));
      end
    end
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_pend_idx = idx;
    cfg_pend_data = val;
    cfg_pending = 1'b1;
    wait (!cfg_pending);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !start && expected_q.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_geometry(logic [12:0] sw, logic [12:0] sh, logic [12:0] iw,
                              logic [12:0] ih, logic [1:0] mode, logic pres,
                              logic [31:0] base);
    write_reg(REG_SCREEN_W, 32'(sw));
    write_reg(REG_SCREEN_H, 32'(sh));
    write_reg(REG_IMAGE_W, 32'(iw));
    write_reg(REG_IMAGE_H, 32'(ih));
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_PRESENT, 32'(pres));
    write_reg(REG_BASE, base);
  endtask

  function automatic logic [12:0] rand_dim();
    case ($urandom_range(5))
      0: return 13'($urandom_range(1, 40));
      1: return 13'($urandom_range(4090, 8191));
      2: return 13'($urandom_range(0, 2));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  // mostly in-range pixels, some anywhere
  function automatic logic [CW-1:0] rand_coord(logic [12:0] lim);
    int unsigned l;
    l = clampd(lim);
    if (l > 0 && $urandom_range(9) < 8) return CW'($urandom_range(0, l - 1));
    return CW'($urandom);
  endfunction

  initial begin
    logic [12:0] sw, sh;
    rst_n = 1'b0;
    start = 1'b0;
    in_dest_x = '0;
    in_dest_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_pending = 1'b0;
    errors = 0;
    checked = 0;
    cycles = 0;
    idle_pct = 16;
    m_sw = 13'd1024;
    m_sh = 13'd768;
    m_iw = 13'd1024;
    m_ih = 13'd768;
    m_mode = MODE_FILL;
    m_present = 1'b0;
    m_base = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, grid and background, band and corners
    pending_q.push_back({12'd0, 12'd0});
    pending_q.push_back({12'd32, 12'd64});
    pending_q.push_back({12'd33, 12'd64});
    pending_q.push_back({12'd1023, 12'd735});
    pending_q.push_back({12'd5, 12'd736});
    pending_q.push_back({12'd1024, 12'd0});
    pending_q.push_back({12'hFFF, 12'hFFF});
    drain();
    for (int m = 0; m < 4; m++) begin
      set_geometry(13'd640, 13'd512, 13'd300, 13'd200, m[1:0], 1'b1, 32'hFFFF_FF00);
      pending_q.push_back({12'd0, 12'd0});
      pending_q.push_back({12'd639, 12'd479});
      pending_q.push_back({12'd170, 12'd140});
      pending_q.push_back({12'd469, 12'd339});
      pending_q.push_back({12'd470, 12'd340});
      drain();
    end
    // oversized and zero dimensions
    set_geometry(13'h1FFF, 13'h1FFF, 13'd0, 13'h1FFF, MODE_TILE, 1'b1, 32'hFFFF_FFFF);
    pending_q.push_back({12'hFFF, 12'd4063});
    pending_q.push_back({12'd7, 12'd9});
    drain();
    write_reg(REG_MODE, 32'(MODE_CENTER));
    pending_q.push_back({12'd7, 12'd9});
    drain();
    write_reg(REG_SCREEN_W, 32'd0);
    pending_q.push_back({12'd0, 12'd0});
    drain();
    set_geometry(13'd1, 13'd32, 13'd4096, 13'd0, MODE_FILL, 1'b1, 32'd0);
    pending_q.push_back({12'd0, 12'd31});
    pending_q.push_back({12'd0, 12'd0});
    drain();

    for (int ph = 0; ph < 19; ph++) begin
      if (ph == 6) idle_pct = 73;
      if (ph == 12) idle_pct = 0;
      sw = rand_dim();
      sh = rand_dim();
      set_geometry(sw, sh, rand_dim(), rand_dim(), 2'($urandom), ($urandom_range(3) != 0),
                   $urandom);
      for (int i = 0; i < 100; i++)
        pending_q.push_back({rand_coord(sw), rand_coord(sh)});
      drain();
    end

    $display("checked %0d pixel results over fill, center, tile and no-image setups,", checked);
    $display("including taskbar band, zero and oversized dimensions");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
